### src/mfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types, register indexes and event codes of the MFM flux decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // default cap on cells inserted for one interval
  localparam int MAX_CELLS_DEF = 8;

  // sync level saturation point
  localparam logic [2:0] SYNC_SAT = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_CELL_LEN   = 3'd1;
  localparam logic [2:0] REG_MAX_INT    = 3'd2;
  localparam logic [2:0] REG_SHORT_SYNC = 3'd3;
  localparam logic [2:0] REG_LONG_SYNC  = 3'd4;

  // event kinds
  localparam logic [1:0] EV_DATA = 2'd0;
  localparam logic [1:0] EV_SYNC = 2'd1;
  localparam logic [1:0] EV_LOSS = 2'd2;

  // word lengths in cells
  localparam logic [5:0] SHORT_CELLS = 6'd16;
  localparam logic [5:0] LONG_CELLS  = 6'd32;

  // one result item without its last marker
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] raw;
    logic        match;
    logic [2:0]  level;
  } result_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take a new interval, clear the event buffer
    logic loss;      // record a sync loss for the accepted interval
    logic insert;    // shift one cell into the decoder
    logic cell_bit;  // value of that cell
    logic move;      // hand the buffered events to the output queue
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic over;     // presented interval is above max_interval
    logic rem_gt;   // remaining time is above 1.5 cells
    logic q_empty;  // output queue holds nothing
  } status_t;

endpackage

### src/mfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_ctrl
// Sequencer: accepts an interval, steps one cell per cycle unless the interval
// is above max_interval, then hands the events of the interval to the output queue.
// ----------------------------------------------------------------------------
module mfd_ctrl #(
  parameter int MAX_CELLS = mfd_pkg::MAX_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mfd_pkg::status_t status,
  output mfd_pkg::cmd_t    cmd
);

  localparam int ZW = $clog2(MAX_CELLS);
  localparam logic [ZW-1:0] ZERO_LIMIT = ZW'(MAX_CELLS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]    state, state_next;
  logic [ZW-1:0] zeros, zeros_next;
  logic          more;

  // another zero cell fits under the cap
  assign more     = status.rem_gt && (zeros < ZERO_LIMIT);
  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    zeros_next = zeros;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          zeros_next = '0;
          if (status.over) begin
            cmd.loss   = 1'b1;
            state_next = ST_FLUSH;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.insert   = 1'b1;
        cmd.cell_bit = !more;
        if (more) begin
          zeros_next = zeros + 1'b1;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.q_empty) begin
          cmd.move   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      zeros <= '0;
    end else begin
      state <= state_next;
      zeros <= zeros_next;
    end
  end

endmodule

### src/mfd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_dp
// Datapath: configuration registers, remaining-time register, cell and data
// shifters, sync counter, two-entry event buffer and two-entry output queue.
// ----------------------------------------------------------------------------
module mfd_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [15:0]       interval,
  input  mfd_pkg::cmd_t     cmd,
  output mfd_pkg::status_t  status,
  input  logic              out_pop,
  output logic              out_valid,
  output mfd_pkg::result_t  out_head,
  output logic              out_last
);

  // configuration
  logic        mode;
  logic [15:0] cell_length;
  logic [15:0] max_interval;
  logic [15:0] short_sync_word;
  logic [31:0] long_sync_word;

  // decoder state
  logic [15:0] rem;
  logic [31:0] cell_shift, cell_shift_next;
  logic [7:0]  data_shift, data_shift_next;
  logic [5:0]  cell_count, cell_count_next;
  logic [2:0]  sync_count, sync_count_next;

  // event buffer and output queue
  mfd_pkg::result_t ev [2];
  logic [1:0]       ev_n;
  mfd_pkg::result_t q [2];
  logic [1:0]       q_n;
  logic             q_last1;

  mfd_pkg::result_t emit_res;
  logic             emit;

  logic [16:0] thr;
  logic [31:0] cell_new;
  logic [7:0]  data_new;
  logic [5:0]  cc1;
  logic [2:0]  sync_inc;
  logic        match16, match32, done;

  // status toward the controller
  assign thr            = {1'b0, cell_length} + {2'b00, cell_length[15:1]};
  assign status.over    = interval > max_interval;
  assign status.rem_gt  = {1'b0, rem} > thr;
  assign status.q_empty = (q_n == 2'd0);

  // single cell step
  assign cell_new = {cell_shift[30:0], cmd.cell_bit};
  assign data_new = cell_count[0] ? {data_shift[6:0], cmd.cell_bit} : data_shift;
  assign cc1      = cell_count + 6'd1;
  assign sync_inc = (sync_count < mfd_pkg::SYNC_SAT) ? sync_count + 3'd1 : mfd_pkg::SYNC_SAT;
  assign match16  = (cell_new[15:0] == short_sync_word);
  assign match32  = (cell_new == long_sync_word);

  always_comb begin
    cell_shift_next = cell_shift;
    data_shift_next = data_shift;
    cell_count_next = cell_count;
    sync_count_next = sync_count;
    emit            = 1'b0;
    emit_res        = '0;
    done            = 1'b0;
    if (cmd.loss) begin
      sync_count_next = '0;
      if (!mode) begin
        cell_shift_next = 32'd1;
      end
      emit           = 1'b1;
      emit_res.kind  = mfd_pkg::EV_LOSS;
      emit_res.raw   = mode ? cell_shift : 32'd1;
      emit_res.level = '0;
    end else if (cmd.insert) begin
      if (!mode) begin
        // byte mode
        done = (sync_count != 3'd0) && (cc1 == mfd_pkg::SHORT_CELLS);
        if (done) begin
          cell_count_next = '0;
          cell_shift_next = cell_new;
          data_shift_next = data_new;
          if (match16) begin
            sync_count_next = sync_inc;
          end
          emit           = 1'b1;
          emit_res.kind  = mfd_pkg::EV_DATA;
          emit_res.data  = data_new;
          emit_res.raw   = cell_new;
          emit_res.match = match16;
        end else if (match16) begin
          cell_count_next = '0;
          cell_shift_next = '0;
          data_shift_next = '0;
          sync_count_next = sync_inc;
          emit            = 1'b1;
          emit_res.kind   = mfd_pkg::EV_SYNC;
          emit_res.raw    = cell_new;
        end else begin
          cell_count_next = cc1;
          cell_shift_next = cell_new;
          data_shift_next = data_new;
        end
      end else begin
        // word mode
        done            = (sync_count != 3'd0) && (cc1 == mfd_pkg::LONG_CELLS);
        cell_shift_next = match32 ? 32'd0 : cell_new;
        cell_count_next = (done || match32) ? 6'd0 : cc1;
        sync_count_next = match32 ? sync_inc : sync_count;
        emit            = done || match32;
        emit_res.kind   = done ? mfd_pkg::EV_DATA : mfd_pkg::EV_SYNC;
        emit_res.raw    = cell_new;
        emit_res.match  = done && match32;
      end
      emit_res.level = sync_count_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= 1'b0;
      cell_length     <= 16'd80;
      max_interval    <= 16'd1000;
      short_sync_word <= 16'h4489;
      long_sync_word  <= 32'h44894489;
    end else if (cfg_we) begin
      case (cfg_index)
        mfd_pkg::REG_MODE:       mode            <= cfg_data[0];
        mfd_pkg::REG_CELL_LEN:   cell_length     <= cfg_data[15:0];
        mfd_pkg::REG_MAX_INT:    max_interval    <= cfg_data[15:0];
        mfd_pkg::REG_SHORT_SYNC: short_sync_word <= cfg_data[15:0];
        mfd_pkg::REG_LONG_SYNC:  long_sync_word  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_shift <= '0;
      data_shift <= '0;
      cell_count <= '0;
      sync_count <= '0;
    end else begin
      cell_shift <= cell_shift_next;
      data_shift <= data_shift_next;
      cell_count <= cell_count_next;
      sync_count <= sync_count_next;
    end
  end

  // remaining time
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= interval;
    end else if (cmd.insert && !cmd.cell_bit) begin
      rem <= rem - cell_length;
    end
  end

  // event buffer, only the first two events of an interval are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_n <= '0;
    end else if (cmd.load) begin
      ev_n <= '0;
    end else if (cmd.loss) begin
      ev_n <= 2'd1;
    end else if (emit && (ev_n != 2'd2)) begin
      ev_n <= ev_n + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.loss) begin
      ev[0] <= emit_res;
    end else if (emit && (ev_n != 2'd2)) begin
      ev[ev_n[0]] <= emit_res;
    end
  end

  // output queue, filled only when empty
  always_ff @(posedge clk) begin
    if (rst) begin
      q_n <= '0;
    end else if (cmd.move) begin
      q_n <= ev_n;
    end else if (out_pop) begin
      q_n <= q_n - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move) begin
      q[0]    <= ev[0];
      q[1]    <= ev[1];
      q_last1 <= 1'b1;
    end else if (out_pop) begin
      q[0] <= q[1];
    end
  end

  assign out_valid = (q_n != 2'd0);
  assign out_head  = q[0];
  assign out_last  = (q_n == 2'd1) && q_last1;

  // checks
  a_sync_sat: assert property (@(posedge clk) disable iff (rst)
    sync_count <= mfd_pkg::SYNC_SAT)
    else $error("sync level above saturation");

  a_move_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.move |-> (q_n == 2'd0))
    else $error("output queue overwritten");

  a_ev_bound: assert property (@(posedge clk) disable iff (rst)
    ev_n != 2'd3)
    else $error("event buffer overflow");

  a_loss_level: assert property (@(posedge clk) disable iff (rst)
    cmd.loss |=> (sync_count == 3'd0) && (ev_n == 2'd1))
    else $error("sync loss not recorded");

endmodule

### src/mfm_flux_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_flux_decoder_top
// MFM flux-transition decoder: turns transition intervals into raw cell
// words, data bytes and sync events.
// ----------------------------------------------------------------------------
// An interval accepted on the input stream that is above max_interval (sync
// loss) inserts no cells: its one result is handed to the output queue.
// Otherwise the decoder inserts one cell per cycle (up to MAX_CELLS), then
// hands its zero to two results to the output queue. The hand-off waits
// while results of the previous interval are still in the queue; after it
// the next interval is taken while these results may still be waiting.
// Results of one interval leave in order, the last marked with tlast.
module mfm_flux_decoder_top #(
  parameter int MAX_CELLS = mfd_pkg::MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // intervals in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // interval[15:0]
  // results out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // data_byte[7:0], raw_word[39:8], sync_match[40],
                                 // sync_level[43:41], zero fill[47:44]
  output logic [1:0]  m_tuser,   // event_kind[1:0]
  output logic        m_tlast    // last_result
);

  mfd_pkg::cmd_t    cmd;
  mfd_pkg::status_t status;
  mfd_pkg::result_t head;

  mfd_ctrl #(
    .MAX_CELLS (MAX_CELLS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mfd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .interval  (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_pop   (m_tvalid && m_tready),
    .out_valid (m_tvalid),
    .out_head  (head),
    .out_last  (m_tlast)
  );

  // result packing
  assign m_tdata = {4'b0000, head.level, head.match, head.raw, head.data};
  assign m_tuser = head.kind;

endmodule

### tb/sv/mfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_checker
// Scoreboard for the MFM flux decoder. It mirrors the register writes, decodes
// every accepted interval with its own copy of the decoder state, and compares
// each result transaction field by field against the oldest expected event.
// ----------------------------------------------------------------------------
module mfd_checker #(
  parameter int MAX_CELLS = mfd_pkg::MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,    // data_byte[7:0], raw_word[39:8], sync_match[40],
                                  // sync_level[43:41], zero fill[47:44]
  input  logic [1:0]  m_tuser,    // event_kind[1:0]
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          n_intervals,
  output int          n_words,
  output int          n_syncs,
  output int          n_losses
);

  // at most this many events of one interval reach the output
  localparam int MAX_EVENTS = 2;

  typedef struct packed {
    mfd_pkg::result_t ev;
    logic             last;
  } flux_event_t;

  // mirrored registers
  logic        word_mode;
  logic [15:0] cell_len;
  logic [15:0] max_gap;
  logic [15:0] short_pat;
  logic [31:0] long_pat;

  // mirrored decoder state
  logic [31:0] cells;
  logic [7:0]  data_bits;
  logic [5:0]  cell_cnt;
  logic [2:0]  sync_lvl;

  flux_event_t due_events[$];
  int          ev_this_interval;
  int          n_results;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("checker: %s mismatch on result %0d at %0t: got 0x%0h, expected 0x%0h",
               what, n_results, $time, got, want);
  endtask

  // queue an event unless this interval already filled its result slots
  task automatic post_event(input logic [1:0] kind, input logic [7:0] data,
                            input logic [31:0] raw, input logic match);
    flux_event_t e;
    if (ev_this_interval < MAX_EVENTS) begin
      e.ev.kind  = kind;
      e.ev.data  = data;
      e.ev.raw   = raw;
      e.ev.match = match;
      e.ev.level = sync_lvl;
      e.last     = 1'b0;
      due_events.push_back(e);
    end
    ev_this_interval++;
  endtask

  task automatic bump_sync();
    if (sync_lvl < mfd_pkg::SYNC_SAT)
      sync_lvl = sync_lvl + 3'd1;
  endtask

  // byte mode: 16-cell words, data byte from the odd cells
  task automatic check_short();
    logic        hit;
    logic [31:0] snap;
    hit = (cells[15:0] == short_pat);
    if (sync_lvl != 3'd0 && cell_cnt == mfd_pkg::SHORT_CELLS) begin
      cell_cnt = '0;
      if (hit) bump_sync();
      post_event(mfd_pkg::EV_DATA, data_bits, cells, hit);
    end else if (hit) begin
      snap      = cells;
      cell_cnt  = '0;
      cells     = '0;
      data_bits = '0;
      bump_sync();
      post_event(mfd_pkg::EV_SYNC, 8'h00, snap, 1'b0);
    end
  endtask

  // word mode: 32-cell words, a matching word clears the shift register
  task automatic check_long();
    logic        done;
    logic        hit;
    logic [31:0] snap;
    done = (sync_lvl != 3'd0 && cell_cnt == mfd_pkg::LONG_CELLS);
    snap = cells;
    hit  = (cells == long_pat);
    if (done) cell_cnt = '0;
    if (hit) begin
      cell_cnt = '0;
      cells    = '0;
      bump_sync();
    end
    if (done)
      post_event(mfd_pkg::EV_DATA, 8'h00, snap, hit);
    else if (hit)
      post_event(mfd_pkg::EV_SYNC, 8'h00, snap, 1'b0);
  endtask

  task automatic shift_cell(input logic b);
    cells = {cells[30:0], b};
    if (!word_mode) begin
      if (cell_cnt[0]) data_bits = {data_bits[6:0], b};
      cell_cnt = cell_cnt + 6'd1;
      check_short();
    end else begin
      cell_cnt = cell_cnt + 6'd1;
      check_long();
    end
  endtask

  // expected events of one flux interval
  task automatic decode_interval(input logic [15:0] ticks);
    int unsigned left;
    int unsigned thr;
    int          zeros;
    flux_event_t e;
    ev_this_interval = 0;
    left = 32'(ticks);
    if (ticks > max_gap) begin
      sync_lvl = '0;
      if (!word_mode) cells = 32'd1;
      post_event(mfd_pkg::EV_LOSS, 8'h00, cells, 1'b0);
    end else begin
      thr   = 32'(cell_len) + 32'(cell_len >> 1);
      zeros = 0;
      while (left > thr && zeros < MAX_CELLS - 1) begin
        left = left - 32'(cell_len);
        shift_cell(1'b0);
        zeros++;
      end
      shift_cell(1'b1);
    end
    if (ev_this_interval > 0) begin
      e = due_events.pop_back();
      e.last = 1'b1;
      due_events.push_back(e);
    end
  endtask

  task automatic check_result();
    flux_event_t e;
    n_results++;
    if (due_events.size() == 0) begin
      report_mismatch("unexpected result", {30'd0, m_tuser}, 32'd0);
      return;
    end
    e = due_events.pop_front();
    if (m_tuser != e.ev.kind)
      report_mismatch("event_kind", {30'd0, m_tuser}, {30'd0, e.ev.kind});
    if (m_tdata[7:0] != e.ev.data)
      report_mismatch("data_byte", {24'd0, m_tdata[7:0]}, {24'd0, e.ev.data});
    if (m_tdata[39:8] != e.ev.raw)
      report_mismatch("raw_word", m_tdata[39:8], e.ev.raw);
    if (m_tdata[40] != e.ev.match)
      report_mismatch("sync_match", {31'd0, m_tdata[40]}, {31'd0, e.ev.match});
    if (m_tdata[43:41] != e.ev.level)
      report_mismatch("sync_level", {29'd0, m_tdata[43:41]}, {29'd0, e.ev.level});
    if (m_tlast != e.last)
      report_mismatch("last_result", {31'd0, m_tlast}, {31'd0, e.last});
    case (e.ev.kind)
      mfd_pkg::EV_DATA: n_words++;
      mfd_pkg::EV_SYNC: n_syncs++;
      default: n_losses++;
    endcase
  endtask

  // watch config, input and output transactions
  always @(posedge clk) begin
    if (rst) begin
      word_mode   = 1'b0;
      cell_len    = 16'd80;
      max_gap     = 16'd1000;
      short_pat   = 16'h4489;
      long_pat    = 32'h44894489;
      cells       = '0;
      data_bits   = '0;
      cell_cnt    = '0;
      sync_lvl    = '0;
      due_events.delete();
      errors      = 0;
      n_intervals = 0;
      n_results   = 0;
      n_words     = 0;
      n_syncs     = 0;
      n_losses    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mfd_pkg::REG_MODE:       word_mode = cfg_data[0];
          mfd_pkg::REG_CELL_LEN:   cell_len  = cfg_data[15:0];
          mfd_pkg::REG_MAX_INT:    max_gap   = cfg_data[15:0];
          mfd_pkg::REG_SHORT_SYNC: short_pat = cfg_data[15:0];
          mfd_pkg::REG_LONG_SYNC:  long_pat  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        decode_interval(s_tdata);
        n_intervals++;
      end
      if (m_tvalid && m_tready) check_result();
    end
    pending = due_events.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MFM flux decoder. Feeds MFM-encoded sectors
// with jittered cell timing, sync patterns, noise and dropouts over several
// register settings, with bursty input and a stalling result consumer.
// ----------------------------------------------------------------------------
module tb;

  localparam int LAT        = mfd_pkg::MAX_CELLS_DEF + 2;
  localparam int IDLE_LIMIT = 4000;

  // consumer stall styles
  localparam int RX_FREE   = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_LONG   = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = mfd_pkg::REG_MODE;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;      // interval[15:0]
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [47:0] m_tdata;           // data_byte[7:0], raw_word[39:8], sync_match[40],
                                  // sync_level[43:41], zero fill[47:44]
  logic [1:0]  m_tuser;           // event_kind[1:0]
  logic        m_tlast;

  int errors, pending, n_intervals, n_words, n_syncs, n_losses;

  // register values as last written
  logic        cur_mode;
  int          cur_len;
  int          cur_max;
  logic [15:0] cur_short;
  logic [31:0] cur_long;

  int   zero_run;
  logic prev_bit;
  int   burst_left;
  int   sent;
  int   idle_cycles;
  int   stall_left;
  int   rx_style;
  int   cyc;

  mfm_flux_decoder_top dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  mfd_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .errors, .pending, .n_intervals, .n_words, .n_syncs, .n_losses
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // result consumer with changing stall styles
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b1;
      stall_left = 0;
      rx_style   = RX_FREE;
      cyc        = 0;
    end else begin
      cyc++;
      if (cyc % 256 == 0) rx_style = $urandom_range(RX_FREE, RX_LONG);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        case (rx_style)
          RX_FREE: m_tready <= 1'b1;
          RX_CHOPPY: begin
            if ($urandom_range(0, 3) == 0) begin
              stall_left = $urandom_range(0, 2);
              m_tready <= 1'b0;
            end else begin
              m_tready <= 1'b1;
            end
          end
          default: begin
            if ($urandom_range(0, 11) == 0) begin
              stall_left = $urandom_range(4, 19);
              m_tready <= 1'b0;
            end else begin
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mfd_pkg::REG_MODE:       cur_mode  = val[0];
      mfd_pkg::REG_CELL_LEN:   cur_len   = int'(val[15:0]);
      mfd_pkg::REG_MAX_INT:    cur_max   = int'(val[15:0]);
      mfd_pkg::REG_SHORT_SYNC: cur_short = val[15:0];
      mfd_pkg::REG_LONG_SYNC:  cur_long  = val;
      default: ;
    endcase
  endtask

  // one interval transaction, bursts separated by random gaps
  task automatic send_interval(input int ticks);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (ticks > 65535) ticks = 65535;
    if (ticks < 0) ticks = 0;
    s_tvalid <= 1'b1;
    s_tdata  <= ticks[15:0];
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // hold input until every expected result has been taken
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic quiesce();
    wait_results();
    repeat (3 * LAT) @(posedge clk);
  endtask

  // ticks for n cells with jitter under half a cell
  function automatic int flux_ticks(input int n);
    int half;
    half = (cur_len > 1) ? (cur_len - 1) / 2 : 0;
    return n * cur_len + int'($urandom_range(0, 2 * half)) - half;
  endfunction

  task automatic put_cell(input logic b);
    if (b) begin
      send_interval(flux_ticks(zero_run + 1));
      zero_run = 0;
    end else begin
      zero_run++;
    end
  endtask

  task automatic put_bits(input logic [31:0] pat, input int w);
    for (int i = w - 1; i >= 0; i--) put_cell(pat[i]);
  endtask

  // mfm: clock cell set only between two zero data bits
  task automatic put_byte(input logic [7:0] d);
    for (int i = 7; i >= 0; i--) begin
      put_cell(!prev_bit && !d[i]);
      put_cell(d[i]);
      prev_bit = d[i];
    end
  endtask

  task automatic put_sync();
    if (cur_mode) put_bits(cur_long, 32);
    else put_bits({16'h0000, cur_short}, 16);
    prev_bit = 1'b1;
  endtask

  // one random stretch of flux: sector, noise, dropout or broken sync
  task automatic send_record();
    int pick;
    int w;
    int k;
    logic [31:0] pat;
    pick = $urandom_range(0, 99);
    w    = cur_mode ? 32 : 16;
    pat  = cur_mode ? cur_long : {16'h0000, cur_short};
    if (pick < 70) begin
      repeat ($urandom_range(1, 3)) put_sync();
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0)
          send_interval($urandom_range(0, 65535));
        else
          send_interval($urandom_range(0, 6 * cur_len + 2));
      end
    end else if (pick < 92) begin
      if (cur_max >= 65535)
        send_interval(65535);
      else if ($urandom_range(0, 1) == 0)
        send_interval(cur_max + 1);
      else
        send_interval($urandom_range(cur_max + 1, 65535));
    end else begin
      k = $urandom_range(1, w - 1);
      put_bits(pat >> k, w - k);
      repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic md, input int len, input int mx,
                           input logic [15:0] sp, input logic [31:0] lp,
                           input int quota);
    int target;
    quiesce();
    set_reg(mfd_pkg::REG_MODE, {31'd0, md});
    set_reg(mfd_pkg::REG_CELL_LEN, 32'(len));
    set_reg(mfd_pkg::REG_MAX_INT, 32'(mx));
    set_reg(mfd_pkg::REG_SHORT_SYNC, {16'h0000, sp});
    set_reg(mfd_pkg::REG_LONG_SYNC, lp);
    target = sent + quota;
    while (sent < target) begin
      send_record();
      if ($urandom_range(0, 29) == 0) wait_results();
    end
  endtask

  initial begin
    int len;
    cur_mode   = 1'b0;
    cur_len    = 80;
    cur_max    = 1000;
    cur_short  = 16'h4489;
    cur_long   = 32'h44894489;
    zero_run   = 0;
    prev_bit   = 1'b0;
    burst_left = 0;
    sent       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // an all-zero pattern keeps matching after the clear: more events than slots
    set_reg(mfd_pkg::REG_SHORT_SYNC, 32'h0000_0000);
    send_interval(700);
    quiesce();
    set_reg(mfd_pkg::REG_SHORT_SYNC, 32'h0000_4489);

    // field extremes, loss at the limit, cell cap, then a synced byte
    send_interval(0);
    send_interval(65535);
    send_interval(1000);
    send_interval(1001);
    put_sync();
    put_byte(8'hA5);
    send_interval(2000);

    // zero cell length: the cap alone bounds the zero cells
    quiesce();
    set_reg(mfd_pkg::REG_CELL_LEN, 32'd0);
    send_interval(5);
    send_interval(0);
    quiesce();

    run_phase(1'b0, 80, 1000, 16'h4489, 32'h44894489, 350);
    run_phase(1'b1, 80, 1000, 16'h4489, 32'h44894489, 350);
    run_phase(1'b0, 1, 65535, 16'($urandom_range(0, 65535)), $urandom(), 250);
    run_phase(1'b1, 65535, 65535, 16'($urandom_range(0, 65535)), 32'hFFFF_FFFF, 200);
    len = $urandom_range(20, 200);
    run_phase(1'b0, len, 5 * len + int'($urandom_range(0, 1000)), 16'hFFFF,
              $urandom(), 250);
    run_phase(1'b1, 0, 0, 16'h0000, 32'h0000_0000, 100);
    len = $urandom_range(30, 120);
    run_phase(1'b1, len, 6 * len + int'($urandom_range(0, 2000)),
              16'($urandom_range(0, 65535)), $urandom(), 250);

    wait_results();
    repeat (4 * LAT) @(posedge clk);
    $display("tb: %0d intervals in byte and word mode over a series of register settings",
             n_intervals);
    $display("tb: checked %0d data words, %0d sync hits, %0d sync losses",
             n_words, n_syncs, n_losses);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
